// ----- rtl/pcr_pkg.sv -----
`timescale 1ns / 1ps

package pcr_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_COORD_BITS  = 24;
	localparam int THRESH_BITS     = 48;
	localparam int CFG_DATA_BITS   = 64;
	localparam int CFG_ADDR_BITS   = 4;

	// register index as seen in paddr[3]
	localparam logic REG_THRESHOLD = 1'b0;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_DEEPER,
		OP_SHALLOWER
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK1,
		ST_CHK2,
		ST_CHK3,
		ST_CHK4,
		ST_DRAIN
	} state_t;

endpackage

// ----- rtl/pcr_cell.sv -----
`timescale 1ns / 1ps

module pcr_cell #(
	parameter int COORD_BITS = pcr_pkg::DEF_COORD_BITS
) (
	input  logic                    clk,
	input  pcr_pkg::cell_op_t       op,
	input  logic [2*COORD_BITS-1:0] shallow,
	input  logic [2*COORD_BITS-1:0] deep,
	output logic [2*COORD_BITS-1:0] data_q
);

	always_ff @(posedge clk) begin
		unique case (op)
			pcr_pkg::OP_DEEPER:    data_q <= shallow;
			pcr_pkg::OP_SHALLOWER: data_q <= deep;
			default:               data_q <= data_q;
		endcase
	end

endmodule

// ----- rtl/pcr_cross.sv -----
`timescale 1ns / 1ps

module pcr_cross #(
	parameter int COORD_BITS = pcr_pkg::DEF_COORD_BITS
) (
	input  logic                            clk,
	input  logic [2*COORD_BITS-1:0]         vert_a,
	input  logic [2*COORD_BITS-1:0]         vert_b,
	input  logic [2*COORD_BITS-1:0]         vert_c,
	input  logic [pcr_pkg::THRESH_BITS-1:0] threshold,
	output logic                            collinear
);

	localparam int DB = COORD_BITS + 1;
	localparam int PB = 2 * DB;
	localparam int SB = PB + 1;
	localparam int CW = (SB > pcr_pkg::THRESH_BITS) ? SB : pcr_pkg::THRESH_BITS;

	logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
	logic signed [DB-1:0] ux_s1, uy_s1, vx_s1, vy_s1;
	logic signed [PB-1:0] p1_s2, p2_s2;
	logic signed [SB-1:0] d_s3;
	logic [SB-1:0] mag;
	logic [CW-1:0] mag_w;
	logic [CW-1:0] thr_w;

	assign ax = vert_a[COORD_BITS-1:0];
	assign ay = vert_a[2*COORD_BITS-1:COORD_BITS];
	assign bx = vert_b[COORD_BITS-1:0];
	assign by = vert_b[2*COORD_BITS-1:COORD_BITS];
	assign cx = vert_c[COORD_BITS-1:0];
	assign cy = vert_c[2*COORD_BITS-1:COORD_BITS];

	always_ff @(posedge clk) begin
		ux_s1 <= DB'(bx) - DB'(ax);
		uy_s1 <= DB'(by) - DB'(ay);
		vx_s1 <= DB'(cx) - DB'(ax);
		vy_s1 <= DB'(cy) - DB'(ay);
		p1_s2 <= PB'(ux_s1) * PB'(vy_s1);
		p2_s2 <= PB'(uy_s1) * PB'(vx_s1);
		d_s3  <= SB'(p1_s2) - SB'(p2_s2);
	end

	assign mag       = d_s3[SB-1] ? SB'(-d_s3) : SB'(d_s3);
	assign mag_w     = CW'(mag);
	assign thr_w     = CW'(threshold);
	assign collinear = (mag_w <= thr_w);

endmodule

// ----- rtl/polyline_collinear_reducer.sv -----
`timescale 1ns / 1ps

// push or drop: a vertex is pushed, or dropped as a duplicate or on overflow;
// each collinearity test on the top three cells runs through the cross product unit
// in ST_CHK1 to ST_CHK4, repeated while the middle vertex is removed; output run: the
// chain shifts to the last cell, then one vertex per cycle while m_tready is high;
// input only in ST_IDLE; arst_n clears count, flags and threshold, not vertex cells
module polyline_collinear_reducer #(
	parameter int STACK_DEPTH = pcr_pkg::DEF_STACK_DEPTH,
	parameter int COORD_BITS  = pcr_pkg::DEF_COORD_BITS,
	parameter int DW          = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pcr_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [pcr_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [pcr_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                              pready,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [DW-1:0]                     s_tdata,  // vertex_x, vertex_y
	input  logic                              s_tlast,  // is_last
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [DW-1:0]                     m_tdata,  // out_x, out_y
	output logic                              m_tlast,  // out_last
	output logic                              m_tuser   // overflowed
);

	localparam int VW = 2 * COORD_BITS;
	localparam int NW = $clog2(STACK_DEPTH + 1);

	pcr_pkg::state_t state_q, state_d;
	pcr_pkg::cell_op_t op_top, op_rest;
	logic [NW-1:0] count_q, count_d;
	logic [NW-1:0] shift_q, shift_d;
	logic ovf_q, ovf_d;
	logic last_q, last_d;
	logic [pcr_pkg::THRESH_BITS-1:0] thresh_q;
	logic [VW-1:0] cell_d [STACK_DEPTH];
	logic [VW-1:0] in_vert;
	logic in_fire, out_fire, dup, aligned, collinear;
	pcr_pkg::state_t fin_state;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[pcr_pkg::CFG_ADDR_BITS-1] == pcr_pkg::REG_THRESHOLD) begin
			thresh_q <= pwdata[pcr_pkg::THRESH_BITS-1:0];
		end
	end

	assign prdata = (paddr[pcr_pkg::CFG_ADDR_BITS-1] == pcr_pkg::REG_THRESHOLD) ?
		pcr_pkg::CFG_DATA_BITS'(thresh_q) : '0;

	assign in_vert  = s_tdata[VW-1:0];
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign dup      = (count_q != '0) && (cell_d[0] == in_vert);
	assign aligned  = ((NW + 1)'(count_q) + (NW + 1)'(shift_q)) == (NW + 1)'(STACK_DEPTH);

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [VW-1:0] shallow_w, deep_w;
		pcr_pkg::cell_op_t op_w;
		if (i == 0) begin : g_top
			assign shallow_w = in_vert;
			assign op_w      = op_top;
		end else begin : g_mid
			assign shallow_w = cell_d[i-1];
			assign op_w      = op_rest;
		end
		if (i == STACK_DEPTH - 1) begin : g_end
			assign deep_w = cell_d[i];
		end else begin : g_inner
			assign deep_w = cell_d[i+1];
		end
		pcr_cell #(.COORD_BITS(COORD_BITS)) u_cell (
			.clk    (clk),
			.op     (op_w),
			.shallow(shallow_w),
			.deep   (deep_w),
			.data_q (cell_d[i])
		);
	end

	pcr_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk      (clk),
		.vert_a   (cell_d[2]),
		.vert_b   (cell_d[1]),
		.vert_c   (cell_d[0]),
		.threshold(thresh_q),
		.collinear(collinear)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcr_pkg::ST_IDLE;
			count_q <= '0;
			shift_q <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			shift_q <= shift_d;
			ovf_q   <= ovf_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		shift_d   = shift_q;
		ovf_d     = ovf_q;
		last_d    = last_q;
		op_top    = pcr_pkg::OP_HOLD;
		op_rest   = pcr_pkg::OP_HOLD;
		fin_state = last_q ? pcr_pkg::ST_DRAIN : pcr_pkg::ST_IDLE;
		unique case (state_q)
			pcr_pkg::ST_IDLE: begin
				if (in_fire) begin
					last_d = s_tlast;
					priority if (dup) begin
						state_d = s_tlast ? pcr_pkg::ST_DRAIN : pcr_pkg::ST_IDLE;
					end else if (count_q == NW'(STACK_DEPTH)) begin
						ovf_d   = 1'b1;
						state_d = s_tlast ? pcr_pkg::ST_DRAIN : pcr_pkg::ST_IDLE;
					end else begin
						op_top  = pcr_pkg::OP_DEEPER;
						op_rest = pcr_pkg::OP_DEEPER;
						count_d = count_q + NW'(1);
						if (count_q >= NW'(2)) begin
							state_d = pcr_pkg::ST_CHK1;
						end else begin
							state_d = s_tlast ? pcr_pkg::ST_DRAIN : pcr_pkg::ST_IDLE;
						end
					end
				end
			end
			pcr_pkg::ST_CHK1: state_d = pcr_pkg::ST_CHK2;
			pcr_pkg::ST_CHK2: state_d = pcr_pkg::ST_CHK3;
			pcr_pkg::ST_CHK3: state_d = pcr_pkg::ST_CHK4;
			pcr_pkg::ST_CHK4: begin
				if (collinear) begin
					op_rest = pcr_pkg::OP_SHALLOWER;
					count_d = count_q - NW'(1);
					state_d = (count_q >= NW'(4)) ? pcr_pkg::ST_CHK1 : fin_state;
				end else begin
					state_d = fin_state;
				end
			end
			pcr_pkg::ST_DRAIN: begin
				if (!aligned) begin
					op_top  = pcr_pkg::OP_DEEPER;
					op_rest = pcr_pkg::OP_DEEPER;
					shift_d = shift_q + NW'(1);
				end else if (m_tready) begin
					op_top  = pcr_pkg::OP_DEEPER;
					op_rest = pcr_pkg::OP_DEEPER;
					if (count_q == NW'(1)) begin
						count_d = '0;
						shift_d = '0;
						ovf_d   = 1'b0;
						last_d  = 1'b0;
						state_d = pcr_pkg::ST_IDLE;
					end else begin
						count_d = count_q - NW'(1);
						shift_d = shift_q + NW'(1);
					end
				end
			end
			default: state_d = pcr_pkg::ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == pcr_pkg::ST_IDLE);
	assign m_tvalid = (state_q == pcr_pkg::ST_DRAIN) && aligned;
	assign m_tdata  = DW'(cell_d[STACK_DEPTH-1]);
	assign m_tlast  = (count_q == NW'(1));
	assign m_tuser  = ovf_q;

endmodule

// ----- rtl/pcr_chk.sv -----
`timescale 1ns / 1ps

module pcr_chk #(
	parameter int DW = 48
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          s_tlast,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [DW-1:0] m_tdata,
	input logic          m_tlast,
	input logic          m_tuser
);

	// stalled output transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output changed while stalled");

	// no vertex taken while a run is being sent
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready during output run");

	// run ends on the tlast transfer
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("output continues after last");

	// a vertex not marked last causes no output
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> !m_tvalid)
		else $error("output without last vertex");

endmodule

bind polyline_collinear_reducer pcr_chk #(.DW(DW)) u_pcr_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);
